/* hw/rtl/edc_pkg.sv */
// ----------------------------------------------------------------------------
// edc_pkg: shared types and constants for the epoch-to-calendar converter
// Holds the split record passed from front to back, the scaled reciprocals
// used by the front splitter and the month length table.
// ----------------------------------------------------------------------------
package edc_pkg;

   // Record handed from the splitter to the calendar walker
   typedef struct packed {
      logic [15:0] days;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } edc_split_type;

   localparam logic [16:0] SecsPerDay  = 17'd86400;
   localparam logic [11:0] SecsPerHour = 12'd3600;
   localparam logic [5:0]  SecsPerMin  = 6'd60;

   // Scaled reciprocals, exact over the operand ranges used by the splitter:
   // (count >> 7) / 675 as a product shifted by 35,
   // (tod >> 4) / 225 as a product shifted by 21,
   // (seconds of hour >> 2) / 15 as a product shifted by 14.
   localparam logic [25:0] DayRecip  = 26'd50903317;
   localparam logic [13:0] HourRecip = 14'd9321;
   localparam logic [10:0] MinRecip  = 11'd1093;

   localparam logic [11:0] EpochYear       = 12'd1970;
   localparam logic [6:0]  EpochYearMod100 = 7'd70;
   localparam logic [6:0]  LastYearMod100  = 7'd99;
   localparam logic [1:0]  EpochCentMod4   = 2'd3;   // century 19
   localparam logic [8:0]  DaysPerYear     = 9'd365;
   localparam logic [8:0]  DaysPerLeapYear = 9'd366;

   localparam logic [3:0] FebIndex    = 4'd1;
   localparam logic [3:0] LastMonth   = 4'd11;
   localparam logic [4:0] FebLeapDays = 5'd29;
   localparam logic [4:0] MonthLen [12] = '{5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
                                            5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      logic [4:0] len;
      if (mon == FebIndex && leap) begin
         len = FebLeapDays;
      end else if (mon <= LastMonth) begin
         len = MonthLen[mon];
      end else begin
         len = MonthLen[0];
      end
      return len;
   endfunction

endpackage

/* hw/rtl/edc_front.sv */
// ----------------------------------------------------------------------------
// edc_front: seconds splitter
// Splits the count into days, hours, minutes and seconds with scaled
// reciprocal products, one multiply or one multiply-and-subtract per cycle.
// ----------------------------------------------------------------------------
module edc_front
   import edc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [31:0]   req_seconds_count,
   output logic          push_valid,
   input  logic          push_ready,
   output edc_split_type push_data
);

   localparam logic [2:0] FrIdle     = 3'd0;
   localparam logic [2:0] FrDays     = 3'd1;
   localparam logic [2:0] FrDaySecs  = 3'd2;
   localparam logic [2:0] FrHour     = 3'd3;
   localparam logic [2:0] FrHourSecs = 3'd4;
   localparam logic [2:0] FrMinute   = 3'd5;
   localparam logic [2:0] FrSecond   = 3'd6;
   localparam logic [2:0] FrPush     = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [31:0] count_ff, count_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] tod_ff, tod_in;       // seconds of the day
   logic [4:0]  hour_ff, hour_in;
   logic [11:0] hrem_ff, hrem_in;     // seconds of the hour
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;

   logic [50:0] day_prod;
   logic [16:0] day_secs;
   logic [25:0] hour_prod;
   logic [11:0] hour_secs;
   logic [19:0] minute_prod;
   logic [5:0]  minute_secs;

   assign day_prod    = 51'(count_ff[31:7]) * 51'(DayRecip);
   // remainders fit their width, so only the low product bits matter
   assign day_secs    = 17'(days_ff) * SecsPerDay;
   assign hour_prod   = 26'(tod_ff[16:4]) * 26'(HourRecip);
   assign hour_secs   = 12'(hour_ff) * SecsPerHour;
   assign minute_prod = 20'(hrem_ff[11:2]) * 20'(MinRecip);
   assign minute_secs = minute_ff * SecsPerMin;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      days_in   = days_ff;
      tod_in    = tod_ff;
      hour_in   = hour_ff;
      hrem_in   = hrem_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      unique case (state_ff)
         FrIdle: begin
            if (req_valid) begin
               count_in = req_seconds_count;
               state_in = FrDays;
            end
         end
         FrDays: begin
            days_in  = day_prod[50:35];
            state_in = FrDaySecs;
         end
         FrDaySecs: begin
            tod_in   = count_ff[16:0] - day_secs;
            state_in = FrHour;
         end
         FrHour: begin
            hour_in  = hour_prod[25:21];
            state_in = FrHourSecs;
         end
         FrHourSecs: begin
            hrem_in  = tod_ff[11:0] - hour_secs;
            state_in = FrMinute;
         end
         FrMinute: begin
            minute_in = minute_prod[19:14];
            state_in  = FrSecond;
         end
         FrSecond: begin
            second_in = hrem_ff[5:0] - minute_secs;
            state_in  = FrPush;
         end
         FrPush: begin
            if (push_ready) begin
               state_in = FrIdle;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FrIdle;
      end else begin
         state_ff <= state_in;
      end
      count_ff  <= count_in;
      days_ff   <= days_in;
      tod_ff    <= tod_in;
      hour_ff   <= hour_in;
      hrem_ff   <= hrem_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
   end

   assign req_ready        = state_ff == FrIdle;
   assign push_valid       = state_ff == FrPush;
   assign push_data.days   = days_ff;
   assign push_data.hour   = hour_ff;
   assign push_data.minute = minute_ff;
   assign push_data.second = second_ff;

endmodule

/* hw/rtl/edc_queue.sv */
// ----------------------------------------------------------------------------
// edc_queue: two-entry queue between splitter and calendar walker
// Lets the splitter finish the next transaction while the walker is busy.
// ----------------------------------------------------------------------------
module edc_queue
   import edc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  edc_split_type push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output edc_split_type pop_data
);

   edc_split_type entry_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/edc_back.sv */
// ----------------------------------------------------------------------------
// edc_back: calendar walker
// Walks whole years from the epoch, then whole months, one per cycle, and
// loads the date and time of day into the result register.
// ----------------------------------------------------------------------------
module edc_back
   import edc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  edc_split_type pop_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [11:0]   rsp_year,
   output logic [3:0]    rsp_month,
   output logic [4:0]    rsp_day,
   output logic [4:0]    rsp_hour,
   output logic [5:0]    rsp_minute,
   output logic [5:0]    rsp_second
);

   localparam logic [1:0] BkIdle  = 2'd0;
   localparam logic [1:0] BkYear  = 2'd1;
   localparam logic [1:0] BkMonth = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [15:0] days_ff, days_in;
   logic [11:0] year_ff, year_in;
   logic [6:0]  ymod_ff, ymod_in;     // year mod 100
   logic [1:0]  cent_ff, cent_in;     // century mod 4
   logic [3:0]  mon_ff, mon_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;

   logic        out_valid_ff, out_valid_in;
   logic [11:0] out_year_ff;
   logic [3:0]  out_month_ff;
   logic [4:0]  out_day_ff, out_hour_ff;
   logic [5:0]  out_minute_ff, out_second_ff;

   logic        leap, year_fits, mon_fits, out_free, load;
   logic [8:0]  year_len;
   logic [4:0]  mon_len;

   assign leap      = (year_ff[1:0] == 2'd0) && (ymod_ff != 7'd0 || cent_ff == 2'd0);
   assign year_len  = leap ? DaysPerLeapYear : DaysPerYear;
   assign year_fits = days_ff >= {7'd0, year_len};
   assign mon_len   = month_days(mon_ff, leap);
   assign mon_fits  = days_ff >= {11'd0, mon_len};
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in  = state_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      ymod_in   = ymod_ff;
      cent_in   = cent_ff;
      mon_in    = mon_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      load      = 1'b0;
      unique case (state_ff)
         BkIdle: begin
            if (pop_valid) begin
               days_in   = pop_data.days;
               hour_in   = pop_data.hour;
               minute_in = pop_data.minute;
               second_in = pop_data.second;
               year_in   = EpochYear;
               ymod_in   = EpochYearMod100;
               cent_in   = EpochCentMod4;
               state_in  = BkYear;
            end
         end
         BkYear: begin
            if (year_fits) begin
               days_in = days_ff - {7'd0, year_len};
               year_in = year_ff + 12'd1;
               if (ymod_ff == LastYearMod100) begin
                  ymod_in = '0;
                  cent_in = cent_ff + 2'd1;
               end else begin
                  ymod_in = ymod_ff + 7'd1;
               end
            end else begin
               mon_in   = '0;
               state_in = BkMonth;
            end
         end
         BkMonth: begin
            if (mon_ff != LastMonth && mon_fits) begin
               days_in = days_ff - {11'd0, mon_len};
               mon_in  = mon_ff + 4'd1;
            end else if (out_free) begin
               // hold here until the result register frees up
               load     = 1'b1;
               state_in = BkIdle;
            end
         end
         default: begin
            state_in = BkIdle;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BkIdle;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      days_ff   <= days_in;
      year_ff   <= year_in;
      ymod_ff   <= ymod_in;
      cent_ff   <= cent_in;
      mon_ff    <= mon_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      if (load) begin
         out_year_ff   <= year_ff;
         out_month_ff  <= mon_ff + 4'd1;
         out_day_ff    <= days_ff[4:0] + 5'd1;
         out_hour_ff   <= hour_ff;
         out_minute_ff <= minute_ff;
         out_second_ff <= second_ff;
      end
   end

   assign pop_ready  = state_ff == BkIdle;
   assign rsp_valid  = out_valid_ff;
   assign rsp_year   = out_year_ff;
   assign rsp_month  = out_month_ff;
   assign rsp_day    = out_day_ff;
   assign rsp_hour   = out_hour_ff;
   assign rsp_minute = out_minute_ff;
   assign rsp_second = out_second_ff;

endmodule

/* hw/rtl/epoch_seconds_to_calendar_date.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date: seconds since 1970 to Gregorian date and time
// Converts an unsigned 32-bit epoch count into year, month, day, hour, minute
// and second.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one 32-bit seconds count per transaction (valid/ready).
//   rsp_* returns one date per transaction, in order (valid/ready).
// Sequence: the splitter runs six multiply steps, one per cycle, then a
//   hand-off; the record passes through the queue; the walker then steps
//   one whole year past 1970 per cycle (0..136), one whole month per cycle
//   (0..11), and then loads and returns the result.
// Throughput: the walker's one-year-per-cycle loop sets the rate; the
//   splitter takes a new count only once it has handed off its last record.
// A two-entry queue sits between splitter and walker, so the splitter takes a
//   new count while the walker or the result register is busy.
// When rsp_ready is low the result holds in its register and the walker waits
//   with the next date; the queue and then req_ready back up behind it.
// Reset (synchronous) empties the queue and drops any pending result.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date
   import edc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_seconds_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second
);

   logic          q_push_valid, q_push_ready;
   logic          q_pop_valid, q_pop_ready;
   edc_split_type q_push_data, q_pop_data;

   edc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_seconds_count (req_seconds_count),
      .push_valid        (q_push_valid),
      .push_ready        (q_push_ready),
      .push_data         (q_push_data)
   );

   edc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   edc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_year   (rsp_year),
      .rsp_month  (rsp_month),
      .rsp_day    (rsp_day),
      .rsp_hour   (rsp_hour),
      .rsp_minute (rsp_minute),
      .rsp_second (rsp_second)
   );

`ifndef SYNTHESIS
   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("splitter accepted a transaction while dividing");

   a_front_hold: assert property (@(posedge clock) disable iff (reset)
      q_push_valid && !q_push_ready |=> q_push_valid && $stable(q_push_data))
      else $error("splitter dropped a split record while the queue was full");

   a_back_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop_valid && q_pop_ready |=> !q_pop_ready)
      else $error("walker took a second record while walking");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_year >= 12'd1970 && rsp_year <= 12'd2106 && rsp_month >= 4'd1
         && rsp_month <= 4'd12 && rsp_day >= 5'd1 && rsp_hour <= 5'd23
         && rsp_minute <= 6'd59 && rsp_second <= 6'd59)
      else $error("result field out of calendar range");
`endif

endmodule

/* tb/edc_calendar_monitor.sv */
// ----------------------------------------------------------------------------
// edc_calendar_monitor: prediction and comparison for the epoch converter
// Watches both channels. Each accepted seconds count is turned into the date
// and time it should give, queued in order, and each accepted result is
// compared field by field with the oldest queued date.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edc_calendar_monitor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_seconds_count,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [11:0] rsp_year,
   input  logic [3:0]  rsp_month,
   input  logic [4:0]  rsp_day,
   input  logic [4:0]  rsp_hour,
   input  logic [5:0]  rsp_minute,
   input  logic [5:0]  rsp_second,
   output int          mismatch_count,
   output int          pending_count,
   output int          checked_count,
   output int          leap_day_count
);

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } civil_date_type;

   localparam int unsigned SecsPerDay  = 86400;
   localparam int unsigned SecsPerHour = 3600;
   localparam int unsigned SecsPerMin  = 60;
   localparam int unsigned FirstYear   = 1970;
   localparam int unsigned February    = 1;
   localparam int unsigned December    = 11;
   localparam int unsigned DaysInMonth [12] = '{31, 28, 31, 30, 31, 30,
                                                31, 31, 30, 31, 30, 31};

   civil_date_type expected_dates[$];
   civil_date_type got_date;
   civil_date_type want_date;
   int             errors = 0;
   int             checked = 0;
   int             leap_days = 0;

   function automatic bit year_has_feb29(input int unsigned yr);
      return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
   endfunction

   function automatic int unsigned year_length(input int unsigned yr);
      return year_has_feb29(yr) ? 366 : 365;
   endfunction

   function automatic civil_date_type civil_date_of(input logic [31:0] secs);
      int unsigned total;
      int unsigned day_num;
      int unsigned tod;
      int unsigned yr;
      int unsigned mon;
      int unsigned len;
      civil_date_type d;
      total   = secs;
      day_num = total / SecsPerDay;
      tod     = total % SecsPerDay;
      yr      = FirstYear;
      mon     = 0;
      while (day_num >= year_length(yr)) begin
         day_num -= year_length(yr);
         yr++;
      end
      while (mon < December) begin
         len = DaysInMonth[mon];
         if (mon == February && year_has_feb29(yr)) len = 29;
         if (day_num < len) break;
         day_num -= len;
         mon++;
      end
      d.year   = yr[11:0];
      d.month  = 4'(mon + 1);
      d.day    = 5'(day_num + 1);
      d.hour   = 5'(tod / SecsPerHour);
      d.minute = 6'((tod % SecsPerHour) / SecsPerMin);
      d.second = 6'(tod % SecsPerMin);
      return d;
   endfunction

   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_dates.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_dates.push_back(civil_date_of(req_seconds_count));
         end
         if (rsp_valid && rsp_ready) begin
            got_date = '{rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second};
            if (expected_dates.size() == 0) begin
               $display({"%0t: result with nothing pending, expected none, ",
                         "actual %0d-%0d-%0d %0d:%0d:%0d"},
                        $time, rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute,
                        rsp_second);
               errors++;
            end else begin
               want_date = expected_dates.pop_front();
               checked++;
               if (want_date.month == 4'd2 && want_date.day == 5'd29) leap_days++;
               check_field("year",   want_date.year,   got_date.year);
               check_field("month",  want_date.month,  got_date.month);
               check_field("day",    want_date.day,    got_date.day);
               check_field("hour",   want_date.hour,   got_date.hour);
               check_field("minute", want_date.minute, got_date.minute);
               check_field("second", want_date.second, got_date.second);
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_dates.size();
      checked_count  <= checked;
      leap_day_count <= leap_days;
   end

endmodule

/* tb/epoch_seconds_to_calendar_date_test.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date_test: regression for the epoch converter
// Sends epoch counts at the range ends, leap days, the century year 2100 and
// day boundaries, then random counts, with random gaps on both channels.
// The monitor beside the block predicts and compares every date.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_date_test;

   localparam int RandomItems  = 880;
   localparam int CalmTail     = 120;
   localparam int QuietLimit   = 4000;
   localparam int SettleCycles = 200;
   localparam int unsigned SecsPerDay = 86400;
   localparam int unsigned LastFullDay = 49709;
   localparam logic [31:0] Year2100Start = 32'd4102444800;

   localparam int EdgeCount = 18;
   localparam logic [31:0] EdgeCounts [EdgeCount] = '{
      32'd0,          32'hFFFF_FFFF,  32'd86399,      32'd86400,
      32'd68169600,   32'd94694399,   32'd946684799,  32'd951782400,
      32'd951868800,  32'd4107542399, 32'd4107542400, 32'd4291747200,
      32'h7FFF_FFFF,  32'h8000_0000,  32'hAAAA_AAAA,  32'h5555_5555,
      32'd31535999,   32'd4102444799
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_seconds_count;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int leap_day_count;
   int sent_count = 0;
   int quiet_cycles = 0;
   int rsp_hold = 0;
   bit gaps_on = 1'b1;

   epoch_seconds_to_calendar_date u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_seconds_count (req_seconds_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second)
   );

   edc_calendar_monitor u_monitor (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_seconds_count (req_seconds_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count),
      .checked_count     (checked_count),
      .leap_day_count    (leap_day_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result side in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_hold  <= $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no transaction for %0d cycles", $time, QuietLimit);
         $display("epoch_seconds_to_calendar_date regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_count(input logic [31:0] secs);
      int gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_seconds_count <= secs;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   // Hold the request side until every pending date has come back
   task automatic drain_dates();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic logic [31:0] pick_count();
      logic [31:0] day_start;
      logic [31:0] v;
      day_start = $urandom_range(0, LastFullDay) * SecsPerDay;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4: v = day_start;
         5: v = day_start + SecsPerDay - 1;
         6: v = 32'hFFFF_FFFF - $urandom_range(0, SecsPerDay * 60);
         7: v = $urandom_range(0, SecsPerDay * 800);
         8: v = Year2100Start - SecsPerDay * 200 + $urandom_range(0, SecsPerDay * 400);
         default: begin
            v = 32'd1 << $urandom_range(0, 31);
            if ($urandom_range(0, 1) == 1) v = ~v;
         end
      endcase
      return v;
   endfunction

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_seconds_count = 32'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < EdgeCount; i++) push_count(EdgeCounts[i]);
      drain_dates();

      for (int i = 0; i < RandomItems; i++) begin
         gaps_on <= (i < RandomItems - CalmTail) && (i % 100 < 70);
         if (i == RandomItems / 2) drain_dates();
         push_count(pick_count());
      end

      drain_dates();
      repeat (SettleCycles) @(posedge clock);

      $display("Converted %0d epoch counts, %0d dates checked, %0d on February 29.",
               sent_count, checked_count, leap_day_count);
      $display("Covered range ends, leap and century years, day edges and random counts.");
      if (mismatch_count == 0) begin
         $display("epoch_seconds_to_calendar_date regression: pass");
      end else begin
         $display("epoch_seconds_to_calendar_date regression: fail");
      end
      $finish;
   end

endmodule
